// ----- design/u8tx_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8tx_pkg
// Shared types and constants of the 8N1 serial transmitter.
// ----------------------------------------------------------------------------
package u8tx_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int QIDX_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
  localparam int FRAME_BITS  = 10;
  localparam int BIDX_W      = 4;
  localparam int PERIOD_W    = 16;
  localparam int BYTE_W      = 8;

  localparam logic [PERIOD_W-1:0] PERIOD_RESET = 16'd104;

  typedef logic [BYTE_W-1:0]     byte_t;
  typedef logic [PERIOD_W-1:0]   period_t;
  typedef logic [QIDX_W-1:0]     qidx_t;
  typedef logic [QCNT_W-1:0]     qcnt_t;
  typedef logic [BIDX_W-1:0]     bidx_t;
  typedef logic [FRAME_BITS-1:0] frame_t;

  typedef enum logic {
    REQ_TICK  = 1'b0,
    REQ_WRITE = 1'b1
  } req_t;

endpackage

// ----- design/u8tx_ifs.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8tx channel interfaces
// Valid/ready channels for request items, result items and configuration.
// ----------------------------------------------------------------------------
interface u8tx_in_if;
  logic                valid;
  logic                ready;
  logic                req_type;
  u8tx_pkg::byte_t     data;

  modport source (output valid, output req_type, output data, input ready);
  modport sink   (input valid, input req_type, input data, output ready);
endinterface

interface u8tx_out_if;
  logic valid;
  logic ready;
  logic tx_line;
  logic busy_res;
  logic accepted;

  modport source (output valid, output tx_line, output busy_res, output accepted,
                  input ready);
  modport sink   (input valid, input tx_line, input busy_res, input accepted,
                  output ready);
endinterface

interface u8tx_cfg_if;
  logic              valid;
  logic              ready;
  u8tx_pkg::period_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

// ----- design/u8tx_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// u8tx_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module u8tx_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      wr_en,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                          wr_data,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
  output logic [WIDTH-1:0]                          rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- design/uart_8n1_transmitter.sv -----
`timescale 1ns / 1ps
// Throughput: one item per clock cycle whenever the result register is free or
// is being drained in that same cycle.
// An item's result sits in the output register in the cycle after it is accepted;
// the RAM is read at the next head address, so a finished frame hands over to the next
// byte on the same tick. Reset (rst_n, synchronous, active low) clears the control
// state and sets the line high; queue contents are left as they are.
// ----------------------------------------------------------------------------
// uart_8n1_transmitter
// Serial 8N1 transmitter, LSB first, with a byte queue held in a RAM.
// ----------------------------------------------------------------------------
module uart_8n1_transmitter (
  input  logic       clk,
  input  logic       rst_n,
  u8tx_in_if.sink    in_chan,
  u8tx_out_if.source out_chan,
  u8tx_cfg_if.sink   cfg_chan
);

  import u8tx_pkg::*;

  // Frame state. The frame shift register holds stop, data and start bits and
  // stays fixed during a frame; the bit index selects the bit on the line.
  frame_t  frame_shift_r, frame_shift_nxt;
  bidx_t   bit_index_r,   bit_index_nxt;
  period_t period_count_r, period_count_nxt;
  logic    sending_r,     sending_nxt;
  logic    line_level_r,  line_level_nxt;
  period_t bit_period_r;

  // Queue bookkeeping. The queue entries live in the RAM.
  qidx_t queue_head_r,  queue_head_nxt;
  qidx_t queue_tail_r,  queue_tail_nxt;
  qcnt_t queue_count_r, queue_count_nxt;

  // RAM port and the write-to-read forwarding path.
  logic  wr_en;
  byte_t ram_rd_data;
  logic  fwd_r,      fwd_nxt;
  byte_t fwd_data_r;
  byte_t head_byte;

  // Result register.
  logic out_valid_r, out_valid_nxt;
  logic out_tx_r;
  logic out_busy_r;
  logic out_acc_r;
  logic acc_nxt;

  logic    item_take;
  period_t period_eff;
  period_t period_inc;
  bidx_t   bit_next;

  // The block takes a new item whenever the result register will be empty.
  assign in_chan.ready  = !out_valid_r || out_chan.ready;
  assign item_take      = in_chan.valid && in_chan.ready;
  assign cfg_chan.ready = 1'b1;

  // A zero bit period behaves as a one-tick period.
  assign period_eff = (bit_period_r == '0) ? period_t'(1) : bit_period_r;
  assign period_inc = period_count_r + period_t'(1);
  assign bit_next   = bit_index_r + bidx_t'(1);

  // The RAM was read at the current head last cycle. If that same entry was
  // being written at the time, the freshly written byte is taken instead.
  assign head_byte = fwd_r ? fwd_data_r : ram_rd_data;

  always_comb begin
    frame_shift_nxt  = frame_shift_r;
    bit_index_nxt    = bit_index_r;
    period_count_nxt = period_count_r;
    sending_nxt      = sending_r;
    line_level_nxt   = line_level_r;
    queue_head_nxt   = queue_head_r;
    queue_tail_nxt   = queue_tail_r;
    queue_count_nxt  = queue_count_r;
    wr_en            = 1'b0;
    acc_nxt          = 1'b0;

    if (item_take) begin
      if (req_t'(in_chan.req_type) == REQ_WRITE) begin
        if (!sending_r && queue_count_r == '0) begin
          // Idle line: the byte goes straight onto the wire.
          frame_shift_nxt  = {1'b1, in_chan.data, 1'b0};
          bit_index_nxt    = '0;
          period_count_nxt = '0;
          sending_nxt      = 1'b1;
          line_level_nxt   = 1'b0;
          acc_nxt          = 1'b1;
        end else if (queue_count_r != qcnt_t'(QUEUE_DEPTH)) begin
          wr_en           = 1'b1;
          queue_tail_nxt  = (queue_tail_r == qidx_t'(QUEUE_DEPTH - 1)) ?
                            '0 : queue_tail_r + qidx_t'(1);
          queue_count_nxt = queue_count_r + qcnt_t'(1);
          acc_nxt         = 1'b1;
        end
      end else if (sending_r) begin
        if (period_inc >= period_eff) begin
          period_count_nxt = '0;
          if (bit_next < bidx_t'(FRAME_BITS)) begin
            bit_index_nxt  = bit_next;
            line_level_nxt = frame_shift_r[bit_next];
          end else if (queue_count_r != '0) begin
            // Stop bit done and a byte waits: start its frame on this tick.
            queue_head_nxt  = (queue_head_r == qidx_t'(QUEUE_DEPTH - 1)) ?
                              '0 : queue_head_r + qidx_t'(1);
            queue_count_nxt = queue_count_r - qcnt_t'(1);
            frame_shift_nxt = {1'b1, head_byte, 1'b0};
            bit_index_nxt   = '0;
            line_level_nxt  = 1'b0;
          end else begin
            sending_nxt    = 1'b0;
            bit_index_nxt  = '0;
            line_level_nxt = 1'b1;
          end
        end else begin
          period_count_nxt = period_inc;
        end
      end
    end
  end

  // Forward a write that lands on the entry being read this cycle.
  assign fwd_nxt = wr_en && (queue_tail_r == queue_head_nxt);

  always_comb begin
    if (item_take) begin
      out_valid_nxt = 1'b1;
    end else begin
      out_valid_nxt = out_valid_r && !out_chan.ready;
    end
  end

  u8tx_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (QUEUE_DEPTH)
  ) u_queue_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (queue_tail_r),
    .wr_data (in_chan.data),
    .rd_addr (queue_head_nxt),
    .rd_data (ram_rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      frame_shift_r  <= '1;
      bit_index_r    <= '0;
      period_count_r <= '0;
      sending_r      <= 1'b0;
      line_level_r   <= 1'b1;
      bit_period_r   <= PERIOD_RESET;
      queue_head_r   <= '0;
      queue_tail_r   <= '0;
      queue_count_r  <= '0;
      fwd_r          <= 1'b0;
      out_valid_r    <= 1'b0;
    end else begin
      frame_shift_r  <= frame_shift_nxt;
      bit_index_r    <= bit_index_nxt;
      period_count_r <= period_count_nxt;
      sending_r      <= sending_nxt;
      line_level_r   <= line_level_nxt;
      queue_head_r   <= queue_head_nxt;
      queue_tail_r   <= queue_tail_nxt;
      queue_count_r  <= queue_count_nxt;
      fwd_r          <= fwd_nxt;
      out_valid_r    <= out_valid_nxt;
      if (cfg_chan.valid && cfg_chan.ready) begin
        bit_period_r <= cfg_chan.data;
      end
    end
  end

  // Payload registers: forwarded byte and result fields.
  always_ff @(posedge clk) begin
    fwd_data_r <= in_chan.data;
    if (item_take) begin
      out_tx_r   <= line_level_nxt;
      out_busy_r <= sending_nxt || (queue_count_nxt != '0);
      out_acc_r  <= acc_nxt;
    end
  end

  assign out_chan.valid    = out_valid_r;
  assign out_chan.tx_line  = out_tx_r;
  assign out_chan.busy_res = out_busy_r;
  assign out_chan.accepted = out_acc_r;

endmodule
